// ----- rtl/kll_pkg.sv -----
package kll_pkg;

	localparam int MAX_DIM      = 64;
	localparam int MAX_CLUSTERS = 256;
	localparam int DIM_W        = 6;
	localparam int CL_W         = 8;
	localparam int ADDR_W       = CL_W + DIM_W;
	localparam int ELEM_W       = 16;
	localparam int SUM_W        = 33;
	localparam int CNT_W        = 17;
	localparam int ACC_W        = 40;

	// op codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_POINT  = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// register indexes
	localparam logic [1:0] CFG_MODE     = 2'd0;
	localparam logic [1:0] CFG_DIMS     = 2'd1;
	localparam logic [1:0] CFG_CLUSTERS = 2'd2;

	// tag that rides along with one scan read
	typedef struct packed {
		logic            vld;
		logic            first;
		logic            last;
		logic [CL_W-1:0] clust;
	} scan_tag_t;

endpackage

// ----- rtl/kll_in_if.sv -----
interface kll_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  cluster_index;
	logic [5:0]  dim_index;
	logic signed [15:0] elem_value;
	logic        point_last;

	modport source (output valid, op, cluster_index, dim_index, elem_value, point_last,
		input ready);
	modport sink (input valid, op, cluster_index, dim_index, elem_value, point_last,
		output ready);
endinterface

// ----- rtl/kll_out_if.sv -----
interface kll_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  assigned_cluster;
	logic        assign_valid;
	logic signed [15:0] read_value;
	logic [8:0]  empty_clusters;

	modport source (output valid, assigned_cluster, assign_valid, read_value,
		empty_clusters, input ready);
	modport sink (input valid, assigned_cluster, assign_valid, read_value,
		empty_clusters, output ready);
endinterface

// ----- rtl/kll_cfg_if.sv -----
interface kll_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [8:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/kll_ram.sv -----
module kll_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/kll_div.sv -----
// serial signed / unsigned divide, one quotient bit per cycle, 16-bit saturated
module kll_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [kll_pkg::SUM_W-1:0]   dividend,
	input  logic [kll_pkg::CNT_W-1:0]          divisor,
	output logic                               done,
	output logic signed [kll_pkg::ELEM_W-1:0]  quot
);

	localparam int SW = kll_pkg::SUM_W;
	localparam int CW = kll_pkg::CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [SW-1:0] mag_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] dsr_q;
	logic          neg_q;
	logic [CW:0]   trial;
	logic          fits;
	logic [CW:0]   diff;

	assign trial = {rem_q, mag_q[SW-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SW-1];
			mag_q <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[SW-2:0], fits};
			rem_q <= fits ? diff[CW-1:0] : trial[CW-1:0];
		end
	end

	always_comb begin
		if (neg_q) begin
			quot = (mag_q > SW'(32768)) ? 16'sh8000 : 16'(-mag_q[15:0]);
		end else begin
			quot = (mag_q > SW'(32767)) ? 16'sh7fff : mag_q[15:0];
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/kll_dist.sv -----
// multiply-accumulate per centroid element, then running best compare
module kll_dist (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              mode,
	input  kll_pkg::scan_tag_t                tag_s1,
	input  logic signed [kll_pkg::ELEM_W-1:0] cv,
	input  logic signed [kll_pkg::ELEM_W-1:0] pv,
	output logic [kll_pkg::CL_W-1:0]          best_c
);

	localparam int AW = kll_pkg::ACC_W;

	kll_pkg::scan_tag_t          tag_s2;
	logic signed [16:0]          df;
	logic signed [16:0]          opa;
	logic signed [16:0]          opb;
	logic signed [33:0]          prod_s2;
	logic signed [AW-1:0]        acc_q;
	logic                        fin_s3;
	logic [kll_pkg::CL_W-1:0]    c_s3;
	logic signed [AW-1:0]        best_q;
	logic [kll_pkg::CL_W-1:0]    best_c_q;
	logic                        take;

	assign df  = {cv[15], cv} - {pv[15], pv};
	assign opa = mode ? {cv[15], cv} : df;
	assign opb = mode ? {pv[15], pv} : df;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			fin_s3 <= 1'b0;
		end else begin
			tag_s2 <= tag_s1;
			fin_s3 <= tag_s2.vld && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= opa * opb;
		c_s3    <= tag_s2.clust;
		if (tag_s2.vld) begin
			acc_q <= tag_s2.first ? AW'(prod_s2) : acc_q + AW'(prod_s2);
		end
	end

	// lower index wins ties: strict compare
	assign take = (c_s3 == '0) || (mode ? (acc_q > best_q) : (acc_q < best_q));

	always_ff @(posedge clk) begin
		if (fin_s3 && take) begin
			best_q   <= acc_q;
			best_c_q <= c_s3;
		end
	end

	assign best_c = best_c_q;

endmodule

// ----- rtl/kmeans_lloyd_pass.sv -----
// Channel   Dir  Fields
// cfg       in   index (0 metric_mode, 1 dims_in_use, 2 clusters_in_use), data
// items     in   op, cluster_index, dim_index, elem_value, point_last
// results   out  assigned_cluster, assign_valid, read_value, empty_clusters
//
// One item at a time; every op gives one result through an output register.
// Ops 0 and 3 and a non-last point element go straight to the result. A last point
// element scans every in-use centroid element (one centroid-memory read per cycle),
// drains the distance pipeline, then updates the winner's sums and count.
// Finish walks all 256x64 entries and runs the serial divide on every in-use
// element of a non-empty cluster.
// After reset a clearing pass zeroes centroids, sums and counts; items wait.
// cfg transfers are taken every cycle.
module kmeans_lloyd_pass (
	input logic        clk,
	input logic        arst_n,
	kll_cfg_if.sink    cfg,
	kll_in_if.sink     items,
	kll_out_if.source  results
);

	localparam int DW = kll_pkg::DIM_W;
	localparam int CL = kll_pkg::CL_W;
	localparam int AD = kll_pkg::ADDR_W;
	localparam int EW = kll_pkg::ELEM_W;
	localparam int SW = kll_pkg::SUM_W;
	localparam int NW = kll_pkg::CNT_W;

	typedef enum logic [11:0] {
		ST_CLEAR   = 12'b0000_0000_0001,
		ST_IDLE    = 12'b0000_0000_0010,
		ST_SCAN    = 12'b0000_0000_0100,
		ST_DRAIN   = 12'b0000_0000_1000,
		ST_ACC     = 12'b0000_0001_0000,
		ST_ACC_END = 12'b0000_0010_0000,
		ST_FIN_CNT = 12'b0000_0100_0000,
		ST_FIN_CHK = 12'b0000_1000_0000,
		ST_FIN_RD  = 12'b0001_0000_0000,
		ST_FIN_GO  = 12'b0010_0000_0000,
		ST_FIN_DIV = 12'b0100_0000_0000,
		ST_RESULT  = 12'b1000_0000_0000
	} state_t;

	state_t st_q;

	// config
	logic       mode_q;
	logic [6:0] dims_q;
	logic [8:0] clus_q;
	logic [6:0] nd;
	logic [8:0] nc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			dims_q <= 7'd64;
			clus_q <= 9'd256;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				kll_pkg::CFG_MODE:     mode_q <= cfg.data[0];
				kll_pkg::CFG_DIMS:     dims_q <= cfg.data[6:0];
				kll_pkg::CFG_CLUSTERS: clus_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// saturate into the usable range, stored bits kept
	assign nd = (dims_q == '0) ? 7'd1 :
		(dims_q > 7'(kll_pkg::MAX_DIM)) ? 7'(kll_pkg::MAX_DIM) : dims_q;
	assign nc = (clus_q == '0) ? 9'd1 :
		(clus_q > 9'(kll_pkg::MAX_CLUSTERS)) ? 9'(kll_pkg::MAX_CLUSTERS) : clus_q;

	// memory ports
	logic          cent_we, cent_re;
	logic [AD-1:0] cent_waddr, cent_raddr;
	logic [EW-1:0] cent_wdata, cent_rdata;
	logic          sum_we, sum_re;
	logic [AD-1:0] sum_waddr, sum_raddr;
	logic [SW-1:0] sum_wdata, sum_rdata;
	logic          cnt_we, cnt_re;
	logic [CL-1:0] cnt_waddr, cnt_raddr;
	logic [NW-1:0] cnt_wdata, cnt_rdata;
	logic          pt_we, pt_re;
	logic [DW-1:0] pt_waddr, pt_raddr;
	logic [EW-1:0] pt_wdata, pt_rdata;

	kll_ram #(.WIDTH(EW), .DEPTH(kll_pkg::MAX_CLUSTERS * kll_pkg::MAX_DIM)) u_cent (
		.clk, .we(cent_we), .waddr(cent_waddr), .wdata(cent_wdata),
		.re(cent_re), .raddr(cent_raddr), .rdata(cent_rdata));
	kll_ram #(.WIDTH(SW), .DEPTH(kll_pkg::MAX_CLUSTERS * kll_pkg::MAX_DIM)) u_sum (
		.clk, .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.re(sum_re), .raddr(sum_raddr), .rdata(sum_rdata));
	kll_ram #(.WIDTH(NW), .DEPTH(kll_pkg::MAX_CLUSTERS)) u_cnt (
		.clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata));
	kll_ram #(.WIDTH(EW), .DEPTH(kll_pkg::MAX_DIM)) u_pt (
		.clk, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.re(pt_re), .raddr(pt_raddr), .rdata(pt_rdata));

	// sequencer registers
	logic [AD-1:0] clr_q;
	logic [CL-1:0] sc_c_q;
	logic [DW-1:0] sc_j_q;
	logic [1:0]    dr_q;
	logic [DW-1:0] aj_q;
	logic [CL-1:0] fc_q;
	logic [DW-1:0] fj_q;
	logic [CL-1:0] win_q;
	logic [8:0]    empty_q;
	logic          active_q;
	logic [NW-1:0] cnt_q;
	logic [1:0]    op_q;
	logic          last_q;
	logic          acc_v_s1, acc_first_s1;
	logic [AD-1:0] acc_addr_s1;
	kll_pkg::scan_tag_t tag_s1;

	logic out_v_q;
	logic out_load;
	logic acc_in;
	logic sc_jl, sc_cl, acc_jl;
	logic act_e;
	logic fin_adv;
	logic [CL-1:0] best_c;
	logic div_start, div_done;
	logic signed [EW-1:0] div_q;
	logic [SW:0] sat_sum;
	logic [SW-1:0] new_sum;
	logic [NW-1:0] new_cnt;

	assign items.ready = (st_q == ST_IDLE);
	assign acc_in      = items.valid && items.ready;

	assign sc_jl  = {1'b0, sc_j_q} == nd - 7'd1;
	assign sc_cl  = {1'b0, sc_c_q} == nc - 9'd1;
	assign acc_jl = {1'b0, aj_q} == nd - 7'd1;
	assign act_e  = active_q && ({1'b0, fj_q} < nd);

	assign out_load = (st_q == ST_RESULT) && (!out_v_q || results.ready);
	// finish walk steps on: after an idle element or a divide that ends
	assign fin_adv  = ((st_q == ST_FIN_GO) && !act_e) || ((st_q == ST_FIN_DIV) && div_done);
	assign div_start = (st_q == ST_FIN_GO) && act_e;

	kll_dist u_dist (
		.clk, .arst_n, .mode(mode_q), .tag_s1,
		.cv(cent_rdata), .pv(pt_rdata), .best_c);

	kll_div u_div (
		.clk, .arst_n, .start(div_start), .dividend(sum_rdata),
		.divisor(cnt_q), .done(div_done), .quot(div_q));

	// saturating sum update: 34-bit sum, clamp where the top two bits differ
	assign sat_sum = {sum_rdata[SW-1], sum_rdata} + (SW + 1)'(signed'(pt_rdata));
	assign new_sum = (sat_sum[SW] == sat_sum[SW-1]) ? sat_sum[SW-1:0] :
		(sat_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});
	assign new_cnt = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + NW'(1);

	// memory port muxing by state
	always_comb begin
		cent_we    = 1'b0;
		cent_waddr = {fc_q, fj_q};
		cent_wdata = div_q;
		cent_re    = 1'b0;
		cent_raddr = {sc_c_q, sc_j_q};
		sum_we     = 1'b0;
		sum_waddr  = {fc_q, fj_q};
		sum_wdata  = '0;
		sum_re     = 1'b0;
		sum_raddr  = {fc_q, fj_q};
		cnt_we     = 1'b0;
		cnt_waddr  = fc_q;
		cnt_wdata  = '0;
		cnt_re     = 1'b0;
		cnt_raddr  = fc_q;
		pt_we      = 1'b0;
		pt_waddr   = items.dim_index;
		pt_wdata   = items.elem_value;
		pt_re      = 1'b0;
		pt_raddr   = sc_j_q;

		unique case (st_q)
			ST_CLEAR: begin
				cent_we    = 1'b1;
				cent_waddr = clr_q;
				cent_wdata = '0;
				sum_we     = 1'b1;
				sum_waddr  = clr_q;
				cnt_we     = 1'b1;
				cnt_waddr  = clr_q[CL-1:0];
			end
			ST_IDLE: begin
				if (acc_in && items.op == kll_pkg::OP_LOAD) begin
					cent_we    = 1'b1;
					cent_waddr = {items.cluster_index, items.dim_index};
					cent_wdata = items.elem_value;
				end
				if (acc_in && items.op == kll_pkg::OP_READ) begin
					cent_re    = 1'b1;
					cent_raddr = {items.cluster_index, items.dim_index};
				end
				if (acc_in && items.op == kll_pkg::OP_POINT
					&& {1'b0, items.dim_index} < nd) begin
					pt_we = 1'b1;
				end
			end
			ST_SCAN: begin
				cent_re = 1'b1;
				pt_re   = 1'b1;
			end
			ST_DRAIN: ;
			ST_ACC, ST_ACC_END: begin
				if (st_q == ST_ACC) begin
					sum_re    = 1'b1;
					sum_raddr = {win_q, aj_q};
					pt_re     = 1'b1;
					pt_raddr  = aj_q;
					cnt_re    = (aj_q == '0);
					cnt_raddr = win_q;
				end
				sum_we    = acc_v_s1;
				sum_waddr = acc_addr_s1;
				sum_wdata = new_sum;
				cnt_we    = acc_v_s1 && acc_first_s1;
				cnt_waddr = win_q;
				cnt_wdata = new_cnt;
			end
			ST_FIN_CNT: cnt_re = 1'b1;
			ST_FIN_CHK: cnt_we = 1'b1;
			ST_FIN_RD:  sum_re = 1'b1;
			ST_FIN_GO:  sum_we = 1'b1;
			ST_FIN_DIV: cent_we = div_done;
			ST_RESULT: ;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			clr_q    <= '0;
			tag_s1   <= '0;
			acc_v_s1 <= 1'b0;
		end else begin
			tag_s1.vld   <= (st_q == ST_SCAN);
			tag_s1.first <= (sc_j_q == '0);
			tag_s1.last  <= sc_jl;
			tag_s1.clust <= sc_c_q;
			acc_v_s1     <= (st_q == ST_ACC);

			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AD'(1);
					if (clr_q == '1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_in) begin
						unique case (items.op)
							kll_pkg::OP_POINT:  st_q <= items.point_last ? ST_SCAN : ST_RESULT;
							kll_pkg::OP_FINISH: st_q <= ST_FIN_CNT;
							default:            st_q <= ST_RESULT;
						endcase
					end
				end
				ST_SCAN: begin
					if (sc_jl && sc_cl) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (dr_q == 2'd3) begin
						st_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (acc_jl) begin
						st_q <= ST_ACC_END;
					end
				end
				ST_ACC_END: st_q <= ST_RESULT;
				ST_FIN_CNT: st_q <= ST_FIN_CHK;
				ST_FIN_CHK: st_q <= ST_FIN_RD;
				ST_FIN_RD:  st_q <= ST_FIN_GO;
				ST_FIN_GO, ST_FIN_DIV: begin
					if (div_start) begin
						st_q <= ST_FIN_DIV;
					end else if (fin_adv) begin
						if (fj_q != '1) begin
							st_q <= ST_FIN_RD;
						end else if (fc_q != '1) begin
							st_q <= ST_FIN_CNT;
						end else begin
							st_q <= ST_RESULT;
						end
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// counters and captured values
	always_ff @(posedge clk) begin
		acc_addr_s1  <= {win_q, aj_q};
		acc_first_s1 <= (aj_q == '0);

		if (acc_in) begin
			op_q   <= items.op;
			last_q <= items.point_last;
			sc_c_q <= '0;
			sc_j_q <= '0;
			dr_q   <= '0;
			aj_q   <= '0;
			fc_q   <= '0;
			fj_q   <= '0;
			empty_q <= '0;
		end

		if (st_q == ST_SCAN) begin
			if (sc_jl) begin
				sc_j_q <= '0;
				sc_c_q <= sc_c_q + CL'(1);
			end else begin
				sc_j_q <= sc_j_q + DW'(1);
			end
		end

		if (st_q == ST_DRAIN) begin
			dr_q <= dr_q + 2'd1;
			win_q <= best_c;
		end

		if (st_q == ST_ACC) begin
			aj_q <= aj_q + DW'(1);
		end

		if (st_q == ST_FIN_CHK) begin
			cnt_q    <= cnt_rdata;
			active_q <= ({1'b0, fc_q} < nc) && (cnt_rdata != '0);
			if (({1'b0, fc_q} < nc) && (cnt_rdata == '0)) begin
				empty_q <= empty_q + 9'd1;
			end
			fj_q <= '0;
		end

		if (fin_adv) begin
			fj_q <= fj_q + DW'(1);
			if (fj_q == '1) begin
				fc_q <= fc_q + CL'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			results.assigned_cluster <= '0;
			results.assign_valid     <= 1'b0;
			results.read_value       <= '0;
			results.empty_clusters   <= '0;
			case (op_q)
				kll_pkg::OP_POINT: begin
					results.assigned_cluster <= last_q ? win_q : '0;
					results.assign_valid     <= last_q;
				end
				kll_pkg::OP_FINISH: results.empty_clusters <= empty_q;
				kll_pkg::OP_READ:   results.read_value     <= cent_rdata;
				default: ;
			endcase
		end
	end

	assign results.valid = out_v_q;

	// no memory update while the scan reads centroids
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> (!cent_we && !sum_we && !cnt_we))
		else $error("memory write during scan");

	// a divide is only started for a cluster that holds points
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (cnt_q != '0))
		else $error("divide by zero count");

	// a loaded result never overwrites one still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_v_q || results.ready))
		else $error("result overwritten");

endmodule

// ----- dv/kmeans_lloyd_pass_tb.sv -----
module kmeans_lloyd_pass_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one transfer on the item channel
	typedef struct {
		logic [1:0]         op;
		logic [7:0]         cluster_index;
		logic [5:0]         dim_index;
		logic signed [15:0] elem_value;
		logic               point_last;
	} item_t;

	// one transfer on the result channel
	typedef struct {
		logic [7:0]         assigned_cluster;
		logic               assign_valid;
		logic signed [15:0] read_value;
		logic [8:0]         empty_clusters;
	} result_t;

	// Shadow of the block: centroids, running sums and counts, point buffer and
	// registers. Every op queues exactly one expected result.
	class cluster_scoreboard;
		shortint     centroid[kll_pkg::MAX_CLUSTERS*kll_pkg::MAX_DIM];
		longint      sums[kll_pkg::MAX_CLUSTERS*kll_pkg::MAX_DIM];
		int unsigned counts[kll_pkg::MAX_CLUSTERS];
		shortint     pbuf[kll_pkg::MAX_DIM];
		bit          ip_mode;
		bit [6:0]    dims_reg;
		bit [8:0]    clus_reg;
		result_t     expected_q[$];
		int          errors;
		int          n_points, n_finish, n_read, n_load;

		function new();
			ip_mode  = 0;
			dims_reg = 7'd64;
			clus_reg = 9'd256;
		endfunction

		// registers saturate into the legal range when used
		function int dims_used();
			if (dims_reg < 1) return 1;
			if (dims_reg > kll_pkg::MAX_DIM) return kll_pkg::MAX_DIM;
			return int'(dims_reg);
		endfunction

		function int clusters_used();
			if (clus_reg < 1) return 1;
			if (clus_reg > kll_pkg::MAX_CLUSTERS) return kll_pkg::MAX_CLUSTERS;
			return int'(clus_reg);
		endfunction

		function void write_reg(logic [1:0] idx, logic [8:0] data);
			case (idx)
				kll_pkg::CFG_MODE:     ip_mode  = data[0];
				kll_pkg::CFG_DIMS:     dims_reg = data[6:0];
				kll_pkg::CFG_CLUSTERS: clus_reg = data;
				default: ;
			endcase
		endfunction

		// least squared distance or greatest dot product, ties to lower index
		function int nearest_cluster();
			int     best;
			longint best_dist, best_ip, sq_dist, ip, df, cv, pv;
			best = 0;
			best_dist = 0;
			best_ip = 0;
			for (int c = 0; c < clusters_used(); c++) begin
				sq_dist = 0;
				ip = 0;
				for (int j = 0; j < dims_used(); j++) begin
					cv = centroid[c*kll_pkg::MAX_DIM + j];
					pv = pbuf[j];
					df = cv - pv;
					sq_dist += df * df;
					ip += cv * pv;
				end
				if (c == 0 || (ip_mode ? (ip > best_ip) : (sq_dist < best_dist))) begin
					best = c;
					best_dist = sq_dist;
					best_ip = ip;
				end
			end
			return best;
		endfunction

		function void add_point(int c);
			longint s;
			for (int j = 0; j < dims_used(); j++) begin
				s = sums[c*kll_pkg::MAX_DIM + j] + pbuf[j];
				if (s > 64'sd4294967295) s = 64'sd4294967295;
				if (s < -64'sd4294967296) s = -64'sd4294967296;
				sums[c*kll_pkg::MAX_DIM + j] = s;
			end
			if (counts[c] < 131071) counts[c]++;
		endfunction

		// centroid update, quotient truncated toward zero and clamped to 16 bits
		function int finish_pass();
			int     empty;
			longint q;
			empty = 0;
			for (int c = 0; c < clusters_used(); c++) begin
				if (counts[c] == 0) begin
					empty++;
				end else begin
					for (int j = 0; j < dims_used(); j++) begin
						q = sums[c*kll_pkg::MAX_DIM + j] / longint'(counts[c]);
						if (q > 32767) q = 32767;
						if (q < -32768) q = -32768;
						centroid[c*kll_pkg::MAX_DIM + j] = shortint'(q);
					end
				end
			end
			foreach (sums[i]) sums[i] = 0;
			foreach (counts[i]) counts[i] = 0;
			return empty;
		endfunction

		function void note_item(item_t it);
			result_t r;
			int      w;
			int      addr;
			r = '{8'd0, 1'b0, 16'sd0, 9'd0};
			addr = it.cluster_index * kll_pkg::MAX_DIM + it.dim_index;
			case (it.op)
				kll_pkg::OP_LOAD: begin
					centroid[addr] = it.elem_value;
					n_load++;
				end
				kll_pkg::OP_POINT: begin
					if (it.dim_index < dims_used()) pbuf[it.dim_index] = it.elem_value;
					if (it.point_last) begin
						w = nearest_cluster();
						add_point(w);
						r.assigned_cluster = w[7:0];
						r.assign_valid = 1'b1;
						n_points++;
					end
				end
				kll_pkg::OP_FINISH: begin
					w = finish_pass();
					r.empty_clusters = w[8:0];
					n_finish++;
				end
				kll_pkg::OP_READ: begin
					r.read_value = centroid[addr];
					n_read++;
				end
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: cluster %0d read %0d empty %0d",
					got.assigned_cluster, got.read_value, got.empty_clusters);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.assigned_cluster !== e.assigned_cluster) begin
				$error("assigned_cluster: expected %0d, got %0d", e.assigned_cluster,
					got.assigned_cluster);
				errors++;
			end
			if (got.assign_valid !== e.assign_valid) begin
				$error("assign_valid: expected %0d, got %0d", e.assign_valid,
					got.assign_valid);
				errors++;
			end
			if (got.read_value !== e.read_value) begin
				$error("read_value: expected %0d, got %0d", e.read_value, got.read_value);
				errors++;
			end
			if (got.empty_clusters !== e.empty_clusters) begin
				$error("empty_clusters: expected %0d, got %0d", e.empty_clusters,
					got.empty_clusters);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	kll_cfg_if cfg_if ();
	kll_in_if  in_if ();
	kll_out_if out_if ();

	kmeans_lloyd_pass u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.items   (in_if),
		.results (out_if)
	);

	cluster_scoreboard sb = new();

	int burst_left = 0;  // transfers left in the current sender burst
	bit pt_written[kll_pkg::MAX_DIM];  // point buffer entries written since reset

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous cap; the clearing pass, the finish walks and the big scans fit well inside
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver: check on every result transfer, then pick ready from a stall mode that
	// is redrawn at random (always ready, coin flip, or mostly stalled).
	int stall_mode = 0;
	int stall_cnt = 0;
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready)
			sb.check_result('{out_if.assigned_cluster, out_if.assign_valid,
				out_if.read_value, out_if.empty_clusters});
		if (stall_cnt == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_cnt = 64;
		end
		stall_cnt--;
		case (stall_mode)
			0: out_if.ready <= 1'b1;
			1: out_if.ready <= 1'($urandom_range(0, 1));
			default: out_if.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Sender: bursts of random length with random gaps. Valid stays high between
	// back-to-back transfers of a burst.
	task automatic send(logic [1:0] op, logic [7:0] ci, logic [5:0] di,
			logic signed [15:0] val, logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_if.valid         <= 1'b1;
		in_if.op            <= op;
		in_if.cluster_index <= ci;
		in_if.dim_index     <= di;
		in_if.elem_value    <= val;
		in_if.point_last    <= last;
		do @(posedge clk); while (!in_if.ready);
		if (op == kll_pkg::OP_POINT && di < sb.dims_used()) pt_written[di] = 1'b1;
		sb.note_item('{op, ci, di, val, last});
	endtask

	// drop valid, let every expected result come back, then a short settle
	task automatic drain();
		in_if.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (20) @(posedge clk);
	endtask

	// register write, only called while the block is drained
	task automatic write_reg(logic [1:0] idx, logic [8:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// element values: full range, extremes, or tiny so that ties are common
	function automatic logic signed [15:0] elem_val(int style);
		case (style)
			0: return 16'($urandom());
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return $signed(16'($urandom_range(0, 4))) - 16'sd2;
		endcase
	endfunction

	// well-formed point: every used element, last on the final one, sometimes with
	// an element beyond the used width thrown in
	task automatic send_point(int style);
		int nd;
		nd = sb.dims_used();
		for (int j = 0; j < nd; j++) begin
			if (nd < kll_pkg::MAX_DIM && $urandom_range(0, 9) == 0)
				send(kll_pkg::OP_POINT, 8'd0, 6'($urandom_range(nd, kll_pkg::MAX_DIM - 1)),
					elem_val(0), 1'b0);
			send(kll_pkg::OP_POINT, 8'($urandom()), 6'(j), elem_val(style), j == nd - 1);
		end
	endtask

	function automatic bit point_complete();
		for (int j = 0; j < sb.dims_used(); j++)
			if (!pt_written[j]) return 0;
		return 1;
	endfunction

	// one pass: configure, seed some centroids, stream points with noise, finish,
	// read back
	task automatic run_pass(bit mode, int dims, int clus, int n_pts);
		int nd, nc, style, sel;
		drain();
		write_reg(kll_pkg::CFG_MODE, 9'(mode));
		write_reg(kll_pkg::CFG_DIMS, 9'(dims));
		write_reg(kll_pkg::CFG_CLUSTERS, 9'(clus));
		nd = sb.dims_used();
		nc = sb.clusters_used();
		style = $urandom_range(0, 2);
		for (int c = 0; c < nc && c < 8; c++)
			for (int j = 0; j < nd && j < 8; j++)
				if ($urandom_range(0, 2) != 0)
					send(kll_pkg::OP_LOAD, 8'(c), 6'(j), elem_val(style),
						1'($urandom_range(0, 1)));
		for (int p = 0; p < n_pts; p++) begin
			send_point(style);
			// noise between points: stray loads, reads, loose elements
			if ($urandom_range(0, 3) == 0) begin
				sel = $urandom_range(0, 2);
				case (sel)
					0: send(kll_pkg::OP_LOAD, 8'($urandom()), 6'($urandom()), elem_val(0),
						1'b0);
					1: send(kll_pkg::OP_READ, 8'($urandom_range(0, nc - 1)), 6'($urandom()),
						elem_val(0), 1'($urandom_range(0, 1)));
					default: send(kll_pkg::OP_POINT, 8'($urandom()), 6'($urandom()),
						elem_val(style), point_complete() && $urandom_range(0, 1));
				endcase
			end
		end
		send(kll_pkg::OP_FINISH, 8'($urandom()), 6'($urandom()), elem_val(0),
			1'($urandom_range(0, 1)));
		for (int k = 0; k < 4; k++)
			send(kll_pkg::OP_READ, 8'($urandom_range(0, nc - 1)),
				6'($urandom_range(0, nd - 1)), elem_val(0), 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_if.valid  <= 1'b0;
		cfg_if.index  <= kll_pkg::CFG_MODE;
		cfg_if.data   <= '0;
		in_if.valid   <= 1'b0;
		in_if.op      <= kll_pkg::OP_LOAD;
		in_if.cluster_index <= '0;
		in_if.dim_index     <= '0;
		in_if.elem_value    <= '0;
		in_if.point_last    <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes of load/read addresses and values
		write_reg(kll_pkg::CFG_DIMS, 9'd2);
		write_reg(kll_pkg::CFG_CLUSTERS, 9'd300);  // saturates to all clusters
		send(kll_pkg::OP_LOAD, 8'd0, 6'd0, 16'sh7fff, 1'b0);
		send(kll_pkg::OP_LOAD, 8'd255, 6'd63, 16'sh8000, 1'b1);
		send(kll_pkg::OP_LOAD, 8'd1, 6'd1, -16'sd1, 1'b0);
		send(kll_pkg::OP_READ, 8'd0, 6'd0, 16'sd0, 1'b0);
		send(kll_pkg::OP_READ, 8'd255, 6'd63, 16'sh7fff, 1'b1);
		send(kll_pkg::OP_READ, 8'd7, 6'd5, 16'sd0, 1'b0);
		// point with an element past the used width, then an all-zero point (ties)
		send(kll_pkg::OP_POINT, 8'd0, 6'd0, 16'sh7fff, 1'b0);
		send(kll_pkg::OP_POINT, 8'd0, 6'd63, 16'sh8000, 1'b0);
		send(kll_pkg::OP_POINT, 8'd0, 6'd1, 16'sh8000, 1'b1);
		send(kll_pkg::OP_POINT, 8'd0, 6'd0, 16'sd0, 1'b0);
		send(kll_pkg::OP_POINT, 8'd0, 6'd1, 16'sd0, 1'b1);
		send(kll_pkg::OP_FINISH, 8'd0, 6'd0, 16'sd0, 1'b0);
		send(kll_pkg::OP_READ, 8'd0, 6'd0, 16'sd0, 1'b0);
		drain();
		// inner product, zero registers saturate to one, unknown index ignored
		write_reg(kll_pkg::CFG_MODE, 9'd1);
		write_reg(kll_pkg::CFG_DIMS, 9'd0);
		write_reg(kll_pkg::CFG_CLUSTERS, 9'd0);
		write_reg(2'd3, 9'h1ff);
		send(kll_pkg::OP_POINT, 8'd0, 6'd0, -16'sd5, 1'b1);
		send(kll_pkg::OP_FINISH, 8'd0, 6'd0, 16'sd0, 1'b0);
		send(kll_pkg::OP_FINISH, 8'd0, 6'd0, 16'sd0, 1'b0);  // no points: all empty
		send(kll_pkg::OP_READ, 8'd0, 6'd0, 16'sd0, 1'b0);

		// random small passes, one wider pass, one pass above range on both registers
		for (int ph = 0; ph < 4; ph++)
			run_pass(1'($urandom_range(0, 1)), $urandom_range(1, 8), $urandom_range(1, 10),
				$urandom_range(4, 8));
		run_pass(1'b1, 32, 4, 2);
		run_pass(1'b0, 127, 511, 1);  // saturates to the maxima
		send(kll_pkg::OP_FINISH, 8'd0, 6'd0, 16'sd0, 1'b0);
		drain();

		$display("covered %0d points, %0d finishes, %0d reads, %0d centroid loads",
			sb.n_points, sb.n_finish, sb.n_read, sb.n_load);
		$display("both metrics, saturated register settings and extreme element values");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- kmeans_lloyd_pass.f -----
rtl/kll_pkg.sv
rtl/kll_in_if.sv
rtl/kll_out_if.sv
rtl/kll_cfg_if.sv
rtl/kll_ram.sv
rtl/kll_div.sv
rtl/kll_dist.sv
rtl/kmeans_lloyd_pass.sv
dv/kmeans_lloyd_pass_tb.sv
